>>> sv/sacl_pkg.sv
// shared types, codes and a saturating-add helper of the set-associative lru cache lookup
package sacl_pkg;

  // command codes
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_STORE  = 2'd1;
  localparam logic [1:0] CMD_MODIFY = 2'd2;

  // outcome codes
  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_FILL  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;
  localparam logic [1:0] OUT_NONE  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_SET_BITS    = 2'd0;
  localparam logic [1:0] REG_BLOCK_BITS  = 2'd1;
  localparam logic [1:0] REG_WAYS_IN_USE = 2'd2;

  localparam int unsigned CfgDataW = 6;
  localparam int unsigned AddrW    = 64;
  localparam int unsigned StampW   = 64;
  localparam int unsigned TotalW   = 32;

  typedef struct packed {
    logic [1:0]       command;
    logic [AddrW-1:0] address;
  } req_t;

  typedef struct packed {
    logic [1:0]        outcome;
    logic              second_hit;
    logic [TotalW-1:0] hit_total;
    logic [TotalW-1:0] miss_total;
    logic [TotalW-1:0] eviction_total;
  } rsp_t;

  // one cache line as held in the set memory
  typedef struct packed {
    logic              valid;
    logic [AddrW-1:0]  tag;
    logic [StampW-1:0] stamp;
  } line_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_e;

  // saturating add of a small amount
  function automatic logic [TotalW-1:0] sat_add(input logic [TotalW-1:0] x,
                                                input logic [1:0] n);
    logic [TotalW:0] sum;
    sum = {1'b0, x} + {{(TotalW-1){1'b0}}, n};
    if (sum[TotalW]) begin
      return {TotalW{1'b1}};
    end
    return sum[TotalW-1:0];
  endfunction

endpackage

>>> sv/set_assoc_lru_cache_lookup.sv
// set-associative lru cache tag model with one set memory and a way scanner
// an accepted access scans the ways of its set one by one, stopping at the hit way
//   or else at the last active way, then writes the row back; done_o is registered
//   from the write-back, and busy holds off a new access until then; the reserved command answers
//   on the next cycle with no access; results cannot be stalled
// reset: set memory cleared row by row with busy high
module set_assoc_lru_cache_lookup
  import sacl_pkg::*;
#(
  parameter int unsigned MAX_SET_BITS = 6,
  parameter int unsigned MAX_WAYS     = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // command side
  input  logic                start,
  output logic                busy,
  input  req_t                item_i,
  // result side
  output logic                done_o,
  output rsp_t                result_o
);

  localparam int unsigned SetW    = MAX_SET_BITS;
  localparam int unsigned NumSets = 1 << MAX_SET_BITS;
  localparam int unsigned WayW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  // configuration registers
  logic [2:0] set_bits_q;
  logic [5:0] block_bits_q;
  logic [3:0] ways_q;

  // control state
  state_e            state_q, state_d;
  logic [SetW-1:0]   clr_q;
  logic              done_q;
  logic [StampW-1:0] acc_q;
  logic [TotalW-1:0] hits_q, misses_q, evicts_q;

  // per-item working registers
  logic [1:0]             cmd_q;
  logic [AddrW-1:0]       tag_q;
  logic [SetW-1:0]        set_q;
  line_t [MAX_WAYS-1:0]   row_q;
  logic [WayW-1:0]        way_q;
  logic                   hit_q, free_q;
  logic [WayW-1:0]        hit_way_q, free_way_q, old_way_q;
  logic [StampW-1:0]      min_q;
  rsp_t                   result_q;

  // set memory: one row holds every way of a set
  line_t [MAX_WAYS-1:0] set_mem [NumSets];

  // fsm outputs
  logic accept, scan_en, wb_en, clr_en;

  // address split
  logic [3:0]       s_eff;
  logic [6:0]       sb;
  logic [AddrW-1:0] tag_next;
  logic [AddrW-1:0] addr_shift;
  logic [SetW-1:0]  set_mask;
  logic [SetW-1:0]  set_next;
  logic             cmd_ok;

  // active way count, 0 acts as 1 and large values clip to the way count
  logic [4:0]      act_ways;
  logic [WayW-1:0] last_way;

  // scan and write-back
  line_t                cur_line;
  logic                 hit_now;
  logic [WayW-1:0]      victim;
  line_t                new_line;
  line_t [MAX_WAYS-1:0] wr_row;
  logic [StampW-1:0]    stamp_inc;
  logic [1:0]           hit_add;
  logic [TotalW-1:0]    hits_new, misses_new, evicts_new;
  logic                 mem_we;
  logic [SetW-1:0]      mem_waddr;
  line_t [MAX_WAYS-1:0] mem_wdata;

  always_comb begin
    s_eff = ({1'b0, set_bits_q} > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : {1'b0, set_bits_q};
    sb = 7'(s_eff) + 7'(block_bits_q);
    tag_next = (sb >= 7'd64) ? '0 : (item_i.address >> sb);
    addr_shift = item_i.address >> block_bits_q;
    set_mask = ~({SetW{1'b1}} << s_eff);
    set_next = SetW'(addr_shift) & set_mask;
    cmd_ok = (item_i.command <= CMD_MODIFY);
  end

  always_comb begin
    if (ways_q == 4'd0) begin
      act_ways = 5'd1;
    end else if ({1'b0, ways_q} > 5'(MAX_WAYS)) begin
      act_ways = 5'(MAX_WAYS);
    end else begin
      act_ways = {1'b0, ways_q};
    end
    last_way = WayW'(act_ways - 5'd1);
  end

  // scan looks at one way per cycle
  assign cur_line = row_q[way_q];
  assign hit_now  = cur_line.valid && (cur_line.tag == tag_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == {SetW{1'b1}}) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start && cmd_ok) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (hit_now || (way_q == last_way)) state_d = ST_WRITE;
      end
      ST_WRITE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // fsm outputs
  always_comb begin
    busy    = 1'b1;
    accept  = 1'b0;
    scan_en = 1'b0;
    wb_en   = 1'b0;
    clr_en  = 1'b0;
    case (state_q)
      ST_CLEAR: clr_en = 1'b1;
      ST_IDLE: begin
        busy   = 1'b0;
        accept = start;
      end
      ST_SCAN:  scan_en = 1'b1;
      ST_WRITE: wb_en = 1'b1;
      default:  busy = 1'b1;
    endcase
  end

  // write-back: victim choice, refreshed line and new totals
  always_comb begin
    if (hit_q) begin
      victim = hit_way_q;
    end else if (free_q) begin
      victim = free_way_q;
    end else begin
      victim = old_way_q;
    end
    // a modify makes a second access that renews the stamp once more
    stamp_inc = (cmd_q == CMD_MODIFY) ? 64'd2 : 64'd1;
    new_line.valid = 1'b1;
    new_line.tag   = tag_q;
    new_line.stamp = acc_q + stamp_inc;
    wr_row = row_q;
    wr_row[victim] = new_line;
    hit_add = {1'b0, hit_q} + {1'b0, (cmd_q == CMD_MODIFY)};
    hits_new   = sat_add(hits_q, hit_add);
    misses_new = sat_add(misses_q, {1'b0, !hit_q});
    evicts_new = sat_add(evicts_q, {1'b0, !hit_q && !free_q});
  end

  assign mem_we    = clr_en || wb_en;
  assign mem_waddr = clr_en ? clr_q : set_q;
  assign mem_wdata = clr_en ? '0 : wr_row;

  // set memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      set_mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      row_q <= set_mem[set_next];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      done_q       <= 1'b0;
      acc_q        <= '0;
      hits_q       <= '0;
      misses_q     <= '0;
      evicts_q     <= '0;
      set_bits_q   <= 3'd0;
      block_bits_q <= 6'd0;
      ways_q       <= 4'd1;
    end else begin
      state_q <= state_d;
      done_q  <= wb_en || (accept && !cmd_ok);
      if (clr_en) begin
        clr_q <= clr_q + 1'b1;
      end
      if (wb_en) begin
        acc_q    <= acc_q + stamp_inc;
        hits_q   <= hits_new;
        misses_q <= misses_new;
        evicts_q <= evicts_new;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SET_BITS:    set_bits_q   <= cfg_data_i[2:0];
          REG_BLOCK_BITS:  block_bits_q <= cfg_data_i[5:0];
          REG_WAYS_IN_USE: ways_q       <= cfg_data_i[3:0];
          default:         ways_q       <= ways_q;
        endcase
      end
    end
  end

  // per-item datapath, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= item_i.command;
      tag_q  <= tag_next;
      set_q  <= set_next;
      way_q  <= '0;
      hit_q  <= 1'b0;
      free_q <= 1'b0;
      if (!cmd_ok) begin
        // reserved command: no access, report current totals
        result_q.outcome        <= OUT_NONE;
        result_q.second_hit     <= 1'b0;
        result_q.hit_total      <= hits_q;
        result_q.miss_total     <= misses_q;
        result_q.eviction_total <= evicts_q;
      end
    end
    if (scan_en) begin
      way_q <= way_q + 1'b1;
      if (hit_now) begin
        hit_q     <= 1'b1;
        hit_way_q <= way_q;
      end else begin
        // highest invalid way wins, oldest stamp ties go to the lowest way
        if (!cur_line.valid) begin
          free_q     <= 1'b1;
          free_way_q <= way_q;
        end
        if ((way_q == '0) || (cur_line.stamp < min_q)) begin
          min_q     <= cur_line.stamp;
          old_way_q <= way_q;
        end
      end
    end
    if (wb_en) begin
      if (hit_q) begin
        result_q.outcome <= OUT_HIT;
      end else if (free_q) begin
        result_q.outcome <= OUT_FILL;
      end else begin
        result_q.outcome <= OUT_EVICT;
      end
      result_q.second_hit     <= (cmd_q == CMD_MODIFY);
      result_q.hit_total      <= hits_new;
      result_q.miss_total     <= misses_new;
      result_q.eviction_total <= evicts_new;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  // a result never shows while an access is in flight
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // every write-back is followed by exactly its result
  a_wb_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE) |=> done_o)
    else $error("write-back without result");

  // the scan never runs past the active ways
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (way_q <= last_way))
    else $error("scan beyond active ways");

  // hit and miss totals never go down
  a_hits_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_CLEAR) |=> (hits_q >= $past(hits_q)) && (misses_q >= $past(misses_q)))
    else $error("total decreased");

endmodule
